// ----- design/assert_macros.svh -----
// Assertion macros for the design; used by ticket_fifo_with_cancel.
// No dependencies; the bodies are empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Expression must hold at every clock edge outside reset.
`define TFC_ASSERT(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
// Consequent must hold in the same cycle as the antecedent.
`define TFC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define TFC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define TFC_ASSERT(lbl, clk, rst_n, expr)
`define TFC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TFC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- design/tfc_pkg.sv -----
// Package for the ticket queue: sizes, codes and transaction structs.
// No dependencies.
package tfc_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int TICKET_BITS = 8;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int TID_W       = 8;
    localparam int OCC_W       = 5;

    typedef logic [1:0] t_func;
    localparam t_func FN_ENQUEUE  = 2'd0;
    localparam t_func FN_COMPLETE = 2'd1;
    localparam t_func FN_CANCEL   = 2'd2;
    localparam t_func FN_QUERY    = 2'd3;

    typedef logic [1:0] t_code;
    localparam t_code RC_OK       = 2'd0;
    localparam t_code RC_BUSY     = 2'd1;
    localparam t_code RC_NOT_HEAD = 2'd2;
    localparam t_code RC_NOT_QUED = 2'd3;

    typedef logic [1:0] t_status;
    localparam t_status TS_WAITING   = 2'd0;
    localparam t_status TS_ACTIVE    = 2'd1;
    localparam t_status TS_COMPLETED = 2'd2;

    typedef struct packed {
        t_func             func;
        logic [TID_W-1:0]  ticket_id;
    } t_in_item;

    typedef struct packed {
        logic [TID_W-1:0]  ticket_out;
        t_code             result_code;
        t_status           ticket_status;
        logic              head_valid;
        logic [TID_W-1:0]  head_ticket;
        logic [OCC_W-1:0]  occupancy;
    } t_out_item;

endpackage

// ----- design/ticket_fifo_with_cancel.sv -----
// Top level of the ticket queue with cancel.
// Depends on tfc_pkg and assert_macros.svh.
`include "assert_macros.svh"
// How to use this block:
// The input channel carries one request transaction (func, ticket_id) under
// i_in_valid / o_in_stall; the output channel returns exactly one result
// transaction per request under o_out_valid / i_out_stall.
// Enqueue hands out the next ticket number, complete pops the active head,
// cancel removes a ticket from any position, and query only reports status.
// The queue lives in a small memory with one read and one write port, and a
// single comparator checks the stored entries one by one, each read then compared.
// A request passes through a search (the entries visited are at most the
// occupancy, none on an empty queue), a decision step, then for a removal a
// shift of the later entries toward the head, and a final step that posts
// the result. o_in_stall stays high from acceptance until the block is back
// in idle.
// A new request may be accepted while the previous result still waits in the
// output register; the new result then waits until that register is free.
// When the receiver stalls, the result register holds its value.
// Reset empties the queue and restarts ticket numbering at zero.
module ticket_fifo_with_cancel (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  tfc_pkg::t_in_item i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output tfc_pkg::t_out_item o_out
);
    import tfc_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_SCAN_RD  = 7'b0000010,
        ST_SCAN_CMP = 7'b0000100,
        ST_DECIDE   = 7'b0001000,
        ST_SHIFT_RD = 7'b0010000,
        ST_SHIFT_WR = 7'b0100000,
        ST_DONE     = 7'b1000000
    } t_state;

    t_state                 r_state, n_state;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [TICKET_BITS-1:0] r_next, n_next;
    logic [TICKET_BITS-1:0] r_head, n_head;
    logic [TICKET_BITS-1:0] r_key, n_key;
    t_func                  r_func, n_func;
    logic [CNT_W-1:0]       r_idx, n_idx;
    logic [CNT_W-1:0]       r_pos, n_pos;
    logic                   r_found, n_found;
    t_code                  r_code, n_code;
    t_status                r_stat, n_stat;
    logic                   r_out_valid, n_out_valid;
    t_out_item              r_out, n_out;

    // Queue storage: entry 0 is the head.
    logic [TICKET_BITS-1:0] r_mem [QUEUE_DEPTH];
    logic [TICKET_BITS-1:0] r_rdata;
    logic [IDX_W-1:0]       w_raddr;
    logic [IDX_W-1:0]       w_waddr;
    logic [TICKET_BITS-1:0] w_wdata;
    logic                   w_we;
    logic                   w_match;
    logic                   w_in_acc;
    logic                   w_out_free;
    logic [CNT_W-1:0]       w_idx_inc;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_match    = (r_rdata == r_key);
    assign w_idx_inc  = r_idx + CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_next      = r_next;
        n_head      = r_head;
        n_key       = r_key;
        n_func      = r_func;
        n_idx       = r_idx;
        n_pos       = r_pos;
        n_found     = r_found;
        n_code      = r_code;
        n_stat      = r_stat;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        w_raddr     = r_idx[IDX_W-1:0];
        w_waddr     = r_idx[IDX_W-1:0];
        w_wdata     = r_rdata;
        w_we        = 1'b0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_func  = i_in.func;
                    n_key   = (i_in.func == FN_ENQUEUE) ? r_next
                                                        : TICKET_BITS'(i_in.ticket_id);
                    n_idx   = '0;
                    n_found = 1'b0;
                    n_pos   = '0;
                    n_state = (r_count == '0) ? ST_DECIDE : ST_SCAN_RD;
                end
            end
            ST_SCAN_RD: begin
                n_state = ST_SCAN_CMP;
            end
            ST_SCAN_CMP: begin
                if (w_match) begin
                    n_found = 1'b1;
                    n_pos   = r_idx;
                    n_state = ST_DECIDE;
                end else if (w_idx_inc >= r_count) begin
                    n_state = ST_DECIDE;
                end else begin
                    n_idx   = w_idx_inc;
                    n_state = ST_SCAN_RD;
                end
            end
            ST_DECIDE: begin
                n_code  = RC_OK;
                n_state = ST_DONE;
                n_idx   = r_pos;
                case (r_func)
                    FN_ENQUEUE: begin
                        if (r_count >= CNT_W'(QUEUE_DEPTH) || r_found) begin
                            n_code = RC_BUSY;
                            n_stat = !r_found ? TS_COMPLETED
                                   : (r_pos == '0) ? TS_ACTIVE : TS_WAITING;
                        end else begin
                            w_we    = 1'b1;
                            w_waddr = r_count[IDX_W-1:0];
                            w_wdata = r_key;
                            n_count = r_count + CNT_W'(1);
                            n_next  = r_next + TICKET_BITS'(1);
                            if (r_count == '0) begin
                                n_head = r_key;
                                n_stat = TS_ACTIVE;
                            end else begin
                                n_stat = TS_WAITING;
                            end
                        end
                    end
                    FN_COMPLETE: begin
                        if (!r_found) begin
                            n_code = RC_NOT_QUED;
                            n_stat = TS_COMPLETED;
                        end else if (r_pos != '0) begin
                            n_code = RC_NOT_HEAD;
                            n_stat = TS_WAITING;
                        end else begin
                            n_stat  = TS_COMPLETED;
                            n_state = ST_SHIFT_RD;
                        end
                    end
                    FN_CANCEL: begin
                        n_stat = TS_COMPLETED;
                        if (!r_found) begin
                            n_code = RC_NOT_QUED;
                        end else begin
                            n_state = ST_SHIFT_RD;
                        end
                    end
                    default: begin
                        n_stat = !r_found ? TS_COMPLETED
                               : (r_pos == '0) ? TS_ACTIVE : TS_WAITING;
                    end
                endcase
            end
            ST_SHIFT_RD: begin
                // Close the gap: entry idx takes entry idx+1 until the tail.
                if (w_idx_inc >= r_count) begin
                    n_count = r_count - CNT_W'(1);
                    n_state = ST_DONE;
                end else begin
                    w_raddr = w_idx_inc[IDX_W-1:0];
                    n_state = ST_SHIFT_WR;
                end
            end
            ST_SHIFT_WR: begin
                w_we    = 1'b1;
                w_waddr = r_idx[IDX_W-1:0];
                w_wdata = r_rdata;
                if (r_idx == '0) begin
                    n_head = r_rdata;
                end
                n_idx   = w_idx_inc;
                n_state = ST_SHIFT_RD;
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_out_valid         = 1'b1;
                    n_out.ticket_out    = TID_W'(r_key);
                    n_out.result_code   = r_code;
                    n_out.ticket_status = r_stat;
                    n_out.head_valid    = (r_count != '0);
                    n_out.head_ticket   = (r_count != '0) ? TID_W'(r_head) : '0;
                    n_out.occupancy     = OCC_W'(r_count);
                    n_state             = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_next      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_next      <= n_next;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head  <= n_head;
        r_key   <= n_key;
        r_func  <= n_func;
        r_idx   <= n_idx;
        r_pos   <= n_pos;
        r_found <= n_found;
        r_code  <= n_code;
        r_stat  <= n_stat;
        r_out   <= n_out;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `TFC_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(QUEUE_DEPTH))
    `TFC_ASSERT_NXT(a_idle_count_stable, i_clk, i_rst_n, r_state == ST_IDLE, $stable(r_count))
    `TFC_ASSERT_NXT(a_done_posts, i_clk, i_rst_n, (r_state == ST_DONE) && !r_out_valid, o_out_valid)
    `TFC_ASSERT_IMP(a_head_matches_occ, i_clk, i_rst_n, o_out_valid,
        o_out.head_valid == (r_out.occupancy != '0))

endmodule

// ----- test/ticket_queue_checker.sv -----
`timescale 1ns / 1ps
// Checker for the ticket queue: watches both transaction channels, keeps its own queue of
// held tickets and compares each result with the predicted one, field by field.
// Depends on tfc_pkg only.
module ticket_queue_checker (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_in_valid,
    input  logic                                           i_in_stall,
    input  tfc_pkg::t_in_item                              i_in,
    input  logic                                           i_out_valid,
    input  logic                                           i_out_stall,
    input  tfc_pkg::t_out_item                             i_out,
    output int                                             o_failures,
    output int                                             o_pending,
    output int                                             o_live_count,
    output logic [tfc_pkg::QUEUE_DEPTH*tfc_pkg::TID_W-1:0] o_live_flat,
    output logic [tfc_pkg::TID_W-1:0]                      o_next_ticket
);
    import tfc_pkg::*;

    localparam logic [TID_W-1:0] TICKET_MASK = TID_W'((1 << TICKET_BITS) - 1);

    logic [TID_W-1:0] held_tickets[$];
    logic [TID_W-1:0] next_ticket;
    t_out_item        due_results[$];

    function automatic int position_of(logic [TID_W-1:0] t);
        foreach (held_tickets[i]) begin
            if (held_tickets[i] == t) begin
                return i;
            end
        end
        return -1;
    endfunction

    // Applies one request to the held queue and returns the result it must produce.
    function automatic t_out_item resolve_request(t_in_item req);
        t_out_item        res;
        logic [TID_W-1:0] id;
        int               pos;
        id = req.ticket_id & TICKET_MASK;
        res = '0;
        res.ticket_out = id;
        res.result_code = RC_OK;
        case (req.func)
            FN_ENQUEUE: begin
                res.ticket_out = next_ticket;
                if (held_tickets.size() >= QUEUE_DEPTH || position_of(next_ticket) >= 0) begin
                    res.result_code = RC_BUSY;
                end else begin
                    held_tickets.insert(held_tickets.size(), next_ticket);
                    next_ticket = (next_ticket + 1'b1) & TICKET_MASK;
                end
            end
            FN_COMPLETE: begin
                pos = position_of(id);
                if (pos < 0) begin
                    res.result_code = RC_NOT_QUED;
                end else if (pos != 0) begin
                    res.result_code = RC_NOT_HEAD;
                end else begin
                    held_tickets.delete(0);
                end
            end
            FN_CANCEL: begin
                pos = position_of(id);
                if (pos < 0) begin
                    res.result_code = RC_NOT_QUED;
                end else begin
                    held_tickets.delete(pos);
                end
            end
            default: begin
            end
        endcase
        pos = position_of(res.ticket_out);
        if (pos < 0) begin
            res.ticket_status = TS_COMPLETED;
        end else if (pos == 0) begin
            res.ticket_status = TS_ACTIVE;
        end else begin
            res.ticket_status = TS_WAITING;
        end
        res.head_valid = (held_tickets.size() > 0);
        res.head_ticket = (held_tickets.size() > 0) ? held_tickets[0] : '0;
        res.occupancy = OCC_W'(held_tickets.size());
        return res;
    endfunction

    task automatic check_field(string name, logic [TID_W-1:0] want, logic [TID_W-1:0] got,
                               inout bit bad);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            bad = 1'b1;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        bit        bad;
        if (!i_rst_n) begin
            held_tickets.delete();
            due_results.delete();
            next_ticket = '0;
        end else begin
            if ($isunknown(i_out_valid)) begin
                $display("%0t ns: output valid unknown, expected 0 or 1, actual %b",
                         $time, i_out_valid);
                o_failures++;
            end else if (i_out_valid && !i_out_stall) begin
                if (due_results.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, actual %h",
                             $time, i_out);
                    o_failures++;
                end else begin
                    want = due_results[0];
                    due_results.delete(0);
                    bad = 1'b0;
                    check_field("ticket_out", want.ticket_out, i_out.ticket_out, bad);
                    check_field("result_code", TID_W'(want.result_code),
                                TID_W'(i_out.result_code), bad);
                    check_field("ticket_status", TID_W'(want.ticket_status),
                                TID_W'(i_out.ticket_status), bad);
                    check_field("head_valid", TID_W'(want.head_valid),
                                TID_W'(i_out.head_valid), bad);
                    check_field("head_ticket", want.head_ticket, i_out.head_ticket, bad);
                    check_field("occupancy", TID_W'(want.occupancy),
                                TID_W'(i_out.occupancy), bad);
                    if (bad) begin
                        o_failures++;
                    end
                end
            end
            // A result never leaves in the cycle its request is taken, so the compare
            // above always concerns an older transaction.
            if (i_in_valid && !i_in_stall) begin
                due_results.insert(due_results.size(), resolve_request(i_in));
            end
        end
        o_pending = due_results.size();
        o_live_count = held_tickets.size();
        o_live_flat = '0;
        foreach (held_tickets[i]) begin
            o_live_flat[i*TID_W +: TID_W] = held_tickets[i];
        end
        o_next_ticket = next_ticket;
    end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// Top of the ticket queue testbench: clock, reset, request stimulus and result-side stalls.
// Depends on tfc_pkg, ticket_fifo_with_cancel and ticket_queue_checker.
module testbench;
    import tfc_pkg::*;

    localparam int RANDOM_ITEMS = 1500;
    // The slowest request visits each queue entry at most once in its search and shift; the rest is margin.
    localparam int DRAIN_CYCLES = 4 * QUEUE_DEPTH + 16;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    t_in_item                     in_item = '0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    t_out_item                    out_item;

    int                           failures;
    int                           pending;
    int                           live_count;
    logic [QUEUE_DEPTH*TID_W-1:0] live_flat;
    logic [TID_W-1:0]             next_ticket;

    int                           issued = 0;
    bit                           no_gaps = 1'b0;

    // Output-side stall state: the length of the current run and a calm phase in which
    // the receiver never stalls.
    int                           stall_left = 0;
    int                           calm_left = 0;
    bit                           calm = 1'b0;

    always #4 clk = ~clk;

    ticket_fifo_with_cancel DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_item)
    );

    ticket_queue_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in          (in_item),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out         (out_item),
        .o_failures    (failures),
        .o_pending     (pending),
        .o_live_count  (live_count),
        .o_live_flat   (live_flat),
        .o_next_ticket (next_ticket)
    );

    // The receiver stalls in runs: mostly short ones, now and then a long one, and in calm
    // phases not at all. Each run sets out_stall once, so no step sees two assignments.
    always @(negedge clk) begin
        if (calm_left == 0) begin
            calm = ($urandom_range(0, 3) == 0);
            calm_left = $urandom_range(100, 400);
        end else begin
            calm_left--;
        end
        if (stall_left == 0) begin
            if (calm || $urandom_range(0, 1) == 0) begin
                out_stall <= 1'b0;
                stall_left = $urandom_range(1, 6);
            end else begin
                out_stall <= 1'b1;
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                         : $urandom_range(1, 3);
            end
        end else begin
            stall_left--;
        end
    end

    // Idle cycles before the next request: mostly none or a few, rarely a long pause.
    function automatic int pick_gap();
        int unsigned roll;
        if (no_gaps) begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 50) begin
            return 0;
        end else if (roll < 85) begin
            return $urandom_range(1, 3);
        end else if (roll < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [TID_W-1:0] live_at(int idx);
        return live_flat[idx*TID_W +: TID_W];
    endfunction

    // A ticket that is held right now, or any number when the queue is empty.
    function automatic logic [TID_W-1:0] pick_live();
        if (live_count == 0) begin
            return TID_W'($urandom_range(0, 255));
        end
        return live_at($urandom_range(0, live_count - 1));
    endfunction

    // Called at a falling edge. Drives one request transaction, holds it until the block
    // takes it, and returns at the next falling edge, when the checker's view of the queue
    // already includes this transaction. Valid is only lowered when a gap follows, so it
    // never drops and rises within one step.
    task automatic issue_request(t_func func, logic [TID_W-1:0] id);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item <= '{func: func, ticket_id: id};
        do begin
            @(posedge clk);
        end while (!(in_valid && !in_stall));
        issued++;
        @(negedge clk);
    endtask

    // Mostly well-formed traffic: enqueues, completes of the head, cancels and queries of
    // held tickets, with a few misdirected completes and stray requests mixed in.
    task automatic mixed_traffic(int count);
        int unsigned roll;
        repeat (count) begin
            roll = $urandom_range(0, 99);
            if (roll < 35) begin
                issue_request(FN_ENQUEUE, TID_W'($urandom_range(0, 255)));
            end else if (roll < 58) begin
                issue_request(FN_COMPLETE, (live_count > 0) ? live_at(0) : pick_live());
            end else if (roll < 78) begin
                issue_request(FN_CANCEL, pick_live());
            end else if (roll < 92) begin
                // Query either a held ticket or one close to the next number, which is
                // recently finished, still held or not issued yet.
                if ($urandom_range(0, 1) == 0) begin
                    issue_request(FN_QUERY, pick_live());
                end else begin
                    issue_request(FN_QUERY, next_ticket - TID_W'($urandom_range(0, 20))
                                            + TID_W'($urandom_range(0, 2)));
                end
            end else if (live_count > 1) begin
                issue_request(FN_COMPLETE, live_at($urandom_range(1, live_count - 1)));
            end else begin
                issue_request(t_func'($urandom_range(0, 3)), TID_W'($urandom_range(0, 255)));
            end
        end
    endtask

    // Fill the queue to the top, push against the full queue, then empty it again.
    task automatic fill_and_drain();
        int guard;
        guard = 0;
        while (live_count < QUEUE_DEPTH && guard < 2 * QUEUE_DEPTH) begin
            issue_request(FN_ENQUEUE, TID_W'($urandom_range(0, 255)));
            guard++;
        end
        repeat ($urandom_range(1, 2)) begin
            issue_request(FN_ENQUEUE, TID_W'($urandom_range(0, 255)));
        end
        issue_request(FN_QUERY, pick_live());
        while (live_count > 0) begin
            if ($urandom_range(0, 1) == 0) begin
                issue_request(FN_COMPLETE, live_at(0));
            end else begin
                issue_request(FN_CANCEL, pick_live());
            end
        end
    endtask

    // Keep the head in place while the numbering runs all the way around, so that the next
    // number to hand out is still held and an enqueue has to be refused for it.
    task automatic wrap_past_head();
        int guard;
        guard = 0;
        if (live_count == 0) begin
            issue_request(FN_ENQUEUE, '0);
        end
        while (next_ticket != live_at(0) && guard < 700) begin
            if (live_count < QUEUE_DEPTH && $urandom_range(0, 99) < 60) begin
                issue_request(FN_ENQUEUE, TID_W'($urandom_range(0, 255)));
            end else if (live_count > 1) begin
                issue_request(FN_CANCEL, live_at($urandom_range(1, live_count - 1)));
            end else begin
                issue_request(FN_QUERY, live_at(0));
            end
            guard++;
        end
        issue_request(FN_ENQUEUE, TID_W'($urandom_range(0, 255)));
        issue_request(FN_QUERY, live_at(0));
        issue_request(FN_COMPLETE, live_at(0));
        issue_request(FN_ENQUEUE, TID_W'($urandom_range(0, 255)));
    endtask

    initial begin
        int directed_count;
        int episode;
        // Reset is held from the start and released at a falling edge; the first request goes out
        // at that same edge, or after an idle gap.
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // Directed opening. Numbering restarts at zero after reset, so the tickets below
        // are known in advance.
        issue_request(FN_QUERY, 8'h00);      // never issued: reported as completed
        issue_request(FN_ENQUEUE, 8'hFF);    // ticket 0, active at once on an empty queue
        issue_request(FN_ENQUEUE, 8'h00);    // ticket 1
        issue_request(FN_ENQUEUE, 8'h55);    // ticket 2
        issue_request(FN_QUERY, 8'h01);      // waiting
        issue_request(FN_QUERY, 8'h00);      // active
        issue_request(FN_COMPLETE, 8'h01);   // queued but not the head
        issue_request(FN_COMPLETE, 8'h00);   // head completes, ticket 1 takes over
        issue_request(FN_COMPLETE, 8'h00);   // no longer queued
        issue_request(FN_CANCEL, 8'h02);     // cancel at the tail
        issue_request(FN_ENQUEUE, 8'hAA);    // ticket 3
        issue_request(FN_ENQUEUE, 8'h00);    // ticket 4
        issue_request(FN_CANCEL, 8'h03);     // cancel from the middle
        issue_request(FN_CANCEL, 8'h01);     // cancel the head, ticket 4 is promoted
        issue_request(FN_CANCEL, 8'hFF);     // not queued
        issue_request(FN_QUERY, 8'hFF);      // never issued
        issue_request(FN_QUERY, 8'h04);      // active
        issue_request(FN_CANCEL, 8'h04);     // queue runs empty, head_valid drops
        issue_request(FN_COMPLETE, 8'h80);   // complete on an empty queue
        issue_request(FN_QUERY, 8'h04);      // completed
        directed_count = issued;

        // Random part, in episodes. One episode early on runs the numbering around the
        // held head; the rest mix ordinary traffic, full-queue runs and plain noise.
        episode = 0;
        while (issued < directed_count + RANDOM_ITEMS) begin
            no_gaps = ($urandom_range(0, 4) == 0);
            if (episode == 2) begin
                wrap_past_head();
            end else begin
                case ($urandom_range(0, 9))
                    0, 1: fill_and_drain();
                    2: begin
                        repeat ($urandom_range(5, 20)) begin
                            issue_request(t_func'($urandom_range(0, 3)),
                                          TID_W'($urandom_range(0, 255)));
                        end
                    end
                    default: mixed_traffic($urandom_range(20, 60));
                endcase
            end
            episode++;
        end

        // All requests are in: let the remaining results come out, then wait a little
        // longer so that any extra result would still be caught.
        in_valid <= 1'b0;
        while (pending != 0) begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (failures == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog: several times the slowest plausible run.
    initial begin
        #12_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
